[hdl/rescale_coefficient_modular_unit_macros.svh]
// assertion macros shared by the rescale coefficient unit
`ifndef RESCALE_COEFFICIENT_MODULAR_UNIT_MACROS_SVH
`define RESCALE_COEFFICIENT_MODULAR_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define RCMU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define RCMU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/rcmu_pkg.sv]
// shared constants and types of the rescale coefficient unit
`timescale 1ns / 1ps

package rcmu_pkg;

    localparam int WORD_BITS      = 64;
    localparam int HALF_BITS      = 32;
    localparam int CFG_INDEX_BITS = 3;
    localparam int PREP_STAGES    = 3;
    localparam int SHOUP_STAGES   = 5;

    localparam logic [CFG_INDEX_BITS-1:0] REG_DROP_MODULUS      = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HALF_DROP_MODULUS = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LIMB_MODULUS      = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ONE_SHOUP_QUOT    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_INV_DROP_MODULUS  = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_INV_SHOUP_QUOT    = 3'd5;

    // load enables of every pipeline stage
    typedef struct packed {
        logic [PREP_STAGES-1:0]  prep;
        logic [SHOUP_STAGES-1:0] shoup;
        logic                    fin;
    } stage_en_t;

    // 32 x 32 -> 64 multiply
    function automatic logic [WORD_BITS-1:0] mul32(input logic [HALF_BITS-1:0] a,
                                                   input logic [HALF_BITS-1:0] b);
        return {{HALF_BITS{1'b0}}, a} * {{HALF_BITS{1'b0}}, b};
    endfunction

endpackage

[hdl/rcmu_if.sv]
// channel interfaces: coefficient in, result out, register write
`timescale 1ns / 1ps

interface rcmu_coeff_in_if #(parameter int MODULUS_BITS = 62);
    logic                    valid;
    logic                    ready;
    logic                    mode;
    logic [MODULUS_BITS-1:0] coeff_a;
    logic [MODULUS_BITS-1:0] coeff_b;
    logic [MODULUS_BITS-1:0] coeff_c;
    logic                    last_in;

    modport source (output valid, mode, coeff_a, coeff_b, coeff_c, last_in, input ready);
    modport sink   (input valid, mode, coeff_a, coeff_b, coeff_c, last_in, output ready);
endinterface

interface rcmu_coeff_out_if #(parameter int MODULUS_BITS = 62);
    logic                    valid;
    logic                    ready;
    logic [MODULUS_BITS-1:0] result_coeff;
    logic                    last_out;

    modport source (output valid, result_coeff, last_out, input ready);
    modport sink   (input valid, result_coeff, last_out, output ready);
endinterface

interface rcmu_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[hdl/rescale_coefficient_modular_unit.sv]
// top level of the rescale coefficient unit: registers, pipeline control, final correction
//
//  channel     dir  handshake     word
//  cfg         in   valid/ready   index, data (register write, always ready)
//  coeff_in    in   valid/ready   mode, coeff_a, coeff_b, coeff_c, last_in
//  coeff_out   out  valid/ready   result_coeff, last_out
//
//  one word per cycle sustained while coeff_out.ready is high; results leave the output correction stage
//  stages: 3 add/correct, 5 shoup multiply (32x32 partial products), 1 output correction
//  each stage holds a valid bit; a stage loads when it is empty or its successor loads,
//  so bubbles collapse and input is taken while a finished result waits at the output,
//  as long as some stage is still empty
//  rst_n clears valid bits and loads the register defaults; datapath registers keep no reset
`timescale 1ns / 1ps

module rescale_coefficient_modular_unit
    import rcmu_pkg::*;
#(
    parameter int MODULUS_BITS = 62
)
(
    input  logic      clk,
    input  logic      rst_n,
    rcmu_cfg_if.sink  cfg,
    rcmu_coeff_in_if.sink coeff_in,
    rcmu_coeff_out_if.source coeff_out
);

    localparam int STAGES    = PREP_STAGES + SHOUP_STAGES + 1;
    localparam int FIN_STAGE = STAGES - 1;

    // configuration registers
    logic [MODULUS_BITS-1:0] drop_modulus_reg;
    logic [MODULUS_BITS-2:0] half_drop_modulus_reg;
    logic [MODULUS_BITS-1:0] limb_modulus_reg;
    logic [WORD_BITS-1:0]    one_shoup_quotient_reg;
    logic [MODULUS_BITS-1:0] inverse_drop_modulus_reg;
    logic [WORD_BITS-1:0]    inverse_shoup_quotient_reg;

    // pipeline control
    logic [STAGES-1:0] valid_reg;
    logic [STAGES:0]   load;
    stage_en_t         stage_en;

    // datapath between parts
    logic [WORD_BITS-1:0]    prep_x;
    logic                    prep_mode;
    logic                    prep_last;
    logic [WORD_BITS-1:0]    shoup_r;
    logic                    shoup_last;
    logic [WORD_BITS-1:0]    q64;
    logic [WORD_BITS-1:0]    fin_next;
    logic [MODULUS_BITS-1:0] result_reg;
    logic                    last_reg;

    // register writes, never stalled
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drop_modulus_reg           <= MODULUS_BITS'(2);
            half_drop_modulus_reg      <= (MODULUS_BITS-1)'(1);
            limb_modulus_reg           <= MODULUS_BITS'(2);
            one_shoup_quotient_reg     <= '0;
            inverse_drop_modulus_reg   <= '0;
            inverse_shoup_quotient_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_DROP_MODULUS:      drop_modulus_reg <= cfg.data[MODULUS_BITS-1:0];
                REG_HALF_DROP_MODULUS: half_drop_modulus_reg <= cfg.data[MODULUS_BITS-2:0];
                REG_LIMB_MODULUS:      limb_modulus_reg <= cfg.data[MODULUS_BITS-1:0];
                REG_ONE_SHOUP_QUOT:    one_shoup_quotient_reg <= cfg.data;
                REG_INV_DROP_MODULUS:  inverse_drop_modulus_reg <= cfg.data[MODULUS_BITS-1:0];
                REG_INV_SHOUP_QUOT:    inverse_shoup_quotient_reg <= cfg.data;
                default:               ;
            endcase
        end
    end

    // a stage loads when empty or when the stage after it loads
    always_comb
    begin
        load[STAGES] = coeff_out.ready;
        for (int k = STAGES - 1; k >= 0; k--)
        begin
            load[k] = !valid_reg[k] || load[k+1];
        end
        stage_en.prep  = load[PREP_STAGES-1:0];
        stage_en.shoup = load[PREP_STAGES+SHOUP_STAGES-1:PREP_STAGES];
        stage_en.fin   = load[FIN_STAGE];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (load[0])
            begin
                valid_reg[0] <= coeff_in.valid;
            end
            for (int k = 1; k < STAGES; k++)
            begin
                if (load[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    assign coeff_in.ready = load[0];

    rcmu_prep #(
        .MODULUS_BITS (MODULUS_BITS)
    ) u_prep (
        .clk               (clk),
        .en                (stage_en),
        .mode              (coeff_in.mode),
        .coeff_a           (coeff_in.coeff_a),
        .coeff_b           (coeff_in.coeff_b),
        .coeff_c           (coeff_in.coeff_c),
        .last_in           (coeff_in.last_in),
        .drop_modulus      (drop_modulus_reg),
        .half_drop_modulus (half_drop_modulus_reg),
        .limb_modulus      (limb_modulus_reg),
        .x                 (prep_x),
        .x_mode            (prep_mode),
        .x_last            (prep_last)
    );

    rcmu_shoup #(
        .MODULUS_BITS (MODULUS_BITS)
    ) u_shoup (
        .clk                    (clk),
        .en                     (stage_en),
        .x                      (prep_x),
        .x_mode                 (prep_mode),
        .x_last                 (prep_last),
        .limb_modulus           (limb_modulus_reg),
        .one_shoup_quotient     (one_shoup_quotient_reg),
        .inverse_drop_modulus   (inverse_drop_modulus_reg),
        .inverse_shoup_quotient (inverse_shoup_quotient_reg),
        .r                      (shoup_r),
        .r_last                 (shoup_last)
    );

    // final conditional subtract of q, then trim to the coefficient width
    always_comb
    begin
        q64 = {{(WORD_BITS-MODULUS_BITS){1'b0}}, limb_modulus_reg};
        if (shoup_r >= q64)
        begin
            fin_next = shoup_r - q64;
        end
        else
        begin
            fin_next = shoup_r;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en.fin)
        begin
            result_reg <= fin_next[MODULUS_BITS-1:0];
            last_reg   <= shoup_last;
        end
    end

    assign coeff_out.valid        = valid_reg[FIN_STAGE];
    assign coeff_out.result_coeff = result_reg;
    assign coeff_out.last_out     = last_reg;

    `include "rescale_coefficient_modular_unit_macros.svh"

    // a word taken into stage one moves to stage two when stage two loads
    `RCMU_ASSERT_NEXT(a_first_advance, valid_reg[0] && load[1], valid_reg[1], "word lost between stages")
    // a stalled last shoup stage means the output is holding a word
    `RCMU_ASSERT_NOW(a_stall_full, valid_reg[FIN_STAGE-1] && !load[FIN_STAGE-1], coeff_out.valid, "stall without full output")
    // an empty front stage never refuses a word
    `RCMU_ASSERT_NOW(a_ready_bubble, !valid_reg[0], coeff_in.ready, "input refused with empty front stage")
    // a result only appears out of the stage before it
    `RCMU_ASSERT_NOW(a_out_source, $rose(coeff_out.valid), $past(valid_reg[FIN_STAGE-1]), "result without source word")

endmodule

[hdl/rcmu_prep.sv]
// front stages: offset add, first correction, subtract of the remainder
`timescale 1ns / 1ps

module rcmu_prep
    import rcmu_pkg::*;
#(
    parameter int MODULUS_BITS = 62
)
(
    input  logic                    clk,
    input  stage_en_t               en,
    input  logic                    mode,
    input  logic [MODULUS_BITS-1:0] coeff_a,
    input  logic [MODULUS_BITS-1:0] coeff_b,
    input  logic [MODULUS_BITS-1:0] coeff_c,
    input  logic                    last_in,
    input  logic [MODULUS_BITS-1:0] drop_modulus,
    input  logic [MODULUS_BITS-2:0] half_drop_modulus,
    input  logic [MODULUS_BITS-1:0] limb_modulus,
    output logic [WORD_BITS-1:0]    x,
    output logic                    x_mode,
    output logic                    x_last
);

    logic [MODULUS_BITS:0]   sum_reg, sum_next;
    logic [MODULUS_BITS-1:0] c1_reg, c2_reg;
    logic                    mode1_reg, mode2_reg, mode3_reg;
    logic                    last1_reg, last2_reg, last3_reg;
    logic [MODULUS_BITS:0]   t_reg, t_next;
    logic [WORD_BITS-1:0]    x_reg, x_next;
    logic [MODULUS_BITS-1:0] mod_sel;
    logic [WORD_BITS-1:0]    wrap_diff;

    // stage 1: a plus half p, or a plus b
    always_comb
    begin
        sum_next = {1'b0, coeff_a} + {1'b0, (mode ? coeff_b : {1'b0, half_drop_modulus})};
    end

    // stage 2: one subtract of p (remainder) or q (finish)
    always_comb
    begin
        mod_sel = mode1_reg ? limb_modulus : drop_modulus;
        if (sum_reg >= {1'b0, mod_sel})
        begin
            t_next = sum_reg - {1'b0, mod_sel};
        end
        else
        begin
            t_next = sum_reg;
        end
    end

    // stage 3: minus c mod q in finish mode, borrow wraps at the full word
    always_comb
    begin
        wrap_diff = {{(WORD_BITS-MODULUS_BITS-1){1'b0}}, t_reg}
                  + {{(WORD_BITS-MODULUS_BITS){1'b0}}, limb_modulus}
                  - {{(WORD_BITS-MODULUS_BITS){1'b0}}, c2_reg};
        if (!mode2_reg)
        begin
            x_next = {{(WORD_BITS-MODULUS_BITS-1){1'b0}}, t_reg};
        end
        else if (t_reg >= {1'b0, c2_reg})
        begin
            x_next = {{(WORD_BITS-MODULUS_BITS-1){1'b0}}, t_reg - {1'b0, c2_reg}};
        end
        else
        begin
            x_next = wrap_diff;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.prep[0])
        begin
            sum_reg   <= sum_next;
            c1_reg    <= coeff_c;
            mode1_reg <= mode;
            last1_reg <= last_in;
        end
        if (en.prep[1])
        begin
            t_reg     <= t_next;
            c2_reg    <= c1_reg;
            mode2_reg <= mode1_reg;
            last2_reg <= last1_reg;
        end
        if (en.prep[2])
        begin
            x_reg     <= x_next;
            mode3_reg <= mode2_reg;
            last3_reg <= last2_reg;
        end
    end

    assign x      = x_reg;
    assign x_mode = mode3_reg;
    assign x_last = last3_reg;

endmodule

[hdl/rcmu_shoup.sv]
// shoup multiply stages: x*w high word, x*y low word, h*q, difference
`timescale 1ns / 1ps

module rcmu_shoup
    import rcmu_pkg::*;
#(
    parameter int MODULUS_BITS = 62
)
(
    input  logic                    clk,
    input  stage_en_t               en,
    input  logic [WORD_BITS-1:0]    x,
    input  logic                    x_mode,
    input  logic                    x_last,
    input  logic [MODULUS_BITS-1:0] limb_modulus,
    input  logic [WORD_BITS-1:0]    one_shoup_quotient,
    input  logic [MODULUS_BITS-1:0] inverse_drop_modulus,
    input  logic [WORD_BITS-1:0]    inverse_shoup_quotient,
    output logic [WORD_BITS-1:0]    r,
    output logic                    r_last
);

    logic [WORD_BITS-1:0] x64, w64, y64, q64;
    logic [WORD_BITS-1:0] py_lh_full, py_hl_full, g_lh_full, g_hl_full;

    // stage 4 partial products
    logic [WORD_BITS-1:0] pw_ll_reg, pw_lh_reg, pw_hl_reg, pw_hh_reg, py_ll_reg;
    logic [HALF_BITS-1:0] py_lh_reg, py_hl_reg;
    // stage 5
    logic [HALF_BITS+1:0] mid_reg, mid_next;
    logic [WORD_BITS-1:0] hpart_reg, hpart_next, xy5_reg, xy5_next;
    logic [HALF_BITS-1:0] xy_cross;
    // stage 6
    logic [WORD_BITS-1:0] h_reg, h_next, xy6_reg;
    // stage 7
    logic [WORD_BITS-1:0] g_ll_reg, xy7_reg;
    logic [HALF_BITS-1:0] g_lh_reg, g_hl_reg, g_cross;
    // stage 8
    logic [WORD_BITS-1:0] r_reg, r_next;

    logic [SHOUP_STAGES-1:0] last_reg;

    // y is one in remainder mode so both modes share a*y - h*q
    always_comb
    begin
        x64 = x;
        q64 = {{(WORD_BITS-MODULUS_BITS){1'b0}}, limb_modulus};
        w64 = x_mode ? inverse_shoup_quotient : one_shoup_quotient;
        y64 = x_mode ? {{(WORD_BITS-MODULUS_BITS){1'b0}}, inverse_drop_modulus}
                     : {{(WORD_BITS-1){1'b0}}, 1'b1};
        py_lh_full = mul32(x64[HALF_BITS-1:0], y64[WORD_BITS-1:HALF_BITS]);
        py_hl_full = mul32(x64[WORD_BITS-1:HALF_BITS], y64[HALF_BITS-1:0]);
    end

    always_comb
    begin
        mid_next = {2'b0, pw_ll_reg[WORD_BITS-1:HALF_BITS]}
                 + {2'b0, pw_lh_reg[HALF_BITS-1:0]}
                 + {2'b0, pw_hl_reg[HALF_BITS-1:0]};
        hpart_next = pw_hh_reg
                   + {{HALF_BITS{1'b0}}, pw_lh_reg[WORD_BITS-1:HALF_BITS]}
                   + {{HALF_BITS{1'b0}}, pw_hl_reg[WORD_BITS-1:HALF_BITS]};
        xy_cross = py_lh_reg + py_hl_reg;
        xy5_next = py_ll_reg + {xy_cross, {HALF_BITS{1'b0}}};
        h_next   = hpart_reg + {{(WORD_BITS-2){1'b0}}, mid_reg[HALF_BITS+1:HALF_BITS]};
        g_lh_full = mul32(h_reg[HALF_BITS-1:0], q64[WORD_BITS-1:HALF_BITS]);
        g_hl_full = mul32(h_reg[WORD_BITS-1:HALF_BITS], q64[HALF_BITS-1:0]);
        g_cross  = g_lh_reg + g_hl_reg;
        r_next   = xy7_reg - (g_ll_reg + {g_cross, {HALF_BITS{1'b0}}});
    end

    always_ff @(posedge clk)
    begin
        if (en.shoup[0])
        begin
            pw_ll_reg <= mul32(x64[HALF_BITS-1:0], w64[HALF_BITS-1:0]);
            pw_lh_reg <= mul32(x64[HALF_BITS-1:0], w64[WORD_BITS-1:HALF_BITS]);
            pw_hl_reg <= mul32(x64[WORD_BITS-1:HALF_BITS], w64[HALF_BITS-1:0]);
            pw_hh_reg <= mul32(x64[WORD_BITS-1:HALF_BITS], w64[WORD_BITS-1:HALF_BITS]);
            py_ll_reg <= mul32(x64[HALF_BITS-1:0], y64[HALF_BITS-1:0]);
            py_lh_reg <= py_lh_full[HALF_BITS-1:0];
            py_hl_reg <= py_hl_full[HALF_BITS-1:0];
            last_reg[0] <= x_last;
        end
        if (en.shoup[1])
        begin
            mid_reg     <= mid_next;
            hpart_reg   <= hpart_next;
            xy5_reg     <= xy5_next;
            last_reg[1] <= last_reg[0];
        end
        if (en.shoup[2])
        begin
            h_reg       <= h_next;
            xy6_reg     <= xy5_reg;
            last_reg[2] <= last_reg[1];
        end
        if (en.shoup[3])
        begin
            g_ll_reg    <= mul32(h_reg[HALF_BITS-1:0], q64[HALF_BITS-1:0]);
            g_lh_reg    <= g_lh_full[HALF_BITS-1:0];
            g_hl_reg    <= g_hl_full[HALF_BITS-1:0];
            xy7_reg     <= xy6_reg;
            last_reg[3] <= last_reg[2];
        end
        if (en.shoup[4])
        begin
            r_reg       <= r_next;
            last_reg[4] <= last_reg[3];
        end
    end

    assign r      = r_reg;
    assign r_last = last_reg[SHOUP_STAGES-1];

endmodule

[verif/rescale_coefficient_modular_unit_test.sv]
// self-checking testbench of the rescale coefficient unit: random and corner coefficient words
`timescale 1ns / 1ps

module rescale_coefficient_modular_unit_test;
    import rcmu_pkg::*;

    localparam int MODULUS_BITS = 62;

    // operation codes of the mode field
    localparam bit MODE_REMAINDER = 1'b0;
    localparam bit MODE_FINISH    = 1'b1;

    // register indexes past the end of the register list, writes there do nothing
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LOW  = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_HIGH = 3'd7;

    localparam logic [63:0] COEFF_MASK = 64'h3FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] HALF_MASK  = 64'h1FFF_FFFF_FFFF_FFFF;

    // receiver hold-off that backs the pipeline up into the input
    localparam int LONG_HOLD_CYCLES = 60;
    // tail after the last result
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        bit        mode;
        bit [61:0] a;
        bit [61:0] b;
        bit [61:0] c;
        bit        last;
    } coeff_word_t;

    typedef struct {
        bit [61:0] coeff;
        bit        last;
    } rescaled_t;

    // register copy, rescale arithmetic and the queue of rescaled words still due
    class rescaled_coeff_tracker;
        bit [63:0] drop_modulus           = 64'd2;
        bit [63:0] half_drop_modulus      = 64'd1;
        bit [63:0] limb_modulus           = 64'd2;
        bit [63:0] one_shoup_quotient     = 64'd0;
        bit [63:0] inverse_drop_modulus   = 64'd0;
        bit [63:0] inverse_shoup_quotient = 64'd0;
        rescaled_t expected_coeffs[$];
        int        mismatches = 0;

        function void write_register(logic [CFG_INDEX_BITS-1:0] index, logic [63:0] data);
            case (index)
                REG_DROP_MODULUS:      drop_modulus = data & COEFF_MASK;
                REG_HALF_DROP_MODULUS: half_drop_modulus = data & HALF_MASK;
                REG_LIMB_MODULUS:      limb_modulus = data & COEFF_MASK;
                REG_ONE_SHOUP_QUOT:    one_shoup_quotient = data;
                REG_INV_DROP_MODULUS:  inverse_drop_modulus = data & COEFF_MASK;
                REG_INV_SHOUP_QUOT:    inverse_shoup_quotient = data;
                default: ;
            endcase
        endfunction

        function bit [63:0] high_word(bit [63:0] x, bit [63:0] y);
            bit [127:0] prod;
            prod = {64'd0, x} * {64'd0, y};
            return prod[127:64];
        endfunction

        // all sums and Shoup steps wrap at 64 bits, one correction each
        function rescaled_t rescale_coeff(coeff_word_t w);
            bit [63:0] s;
            bit [63:0] t;
            bit [63:0] u;
            bit [63:0] h;
            bit [63:0] r;
            bit [63:0] c;
            rescaled_t res;
            c = {2'b00, w.c};
            if (w.mode == MODE_REMAINDER)
            begin
                s = {2'b00, w.a} + half_drop_modulus;
                if (s >= drop_modulus)
                    s = s - drop_modulus;
                h = high_word(s, one_shoup_quotient);
                r = s - h * limb_modulus;
            end
            else
            begin
                t = {2'b00, w.a} + {2'b00, w.b};
                if (t >= limb_modulus)
                    t = t - limb_modulus;
                u = (t >= c) ? t - c : t + limb_modulus - c;
                h = high_word(u, inverse_shoup_quotient);
                r = u * inverse_drop_modulus - h * limb_modulus;
            end
            if (r >= limb_modulus)
                r = r - limb_modulus;
            res.coeff = r[61:0];
            res.last  = w.last;
            return res;
        endfunction

        function void note_word(coeff_word_t w);
            expected_coeffs.push_back(rescale_coeff(w));
        endfunction

        function void check_result(logic [61:0] coeff, logic last);
            rescaled_t due;
            if (expected_coeffs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result word with none due: coeff %h last %b",
                             $realtime, coeff, last);
            end
            else
            begin
                due = expected_coeffs.pop_front();
                if (coeff !== due.coeff || last !== due.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: mismatch: coeff exp %h got %h, last exp %b got %b",
                                 $realtime, due.coeff, coeff, due.last, last);
                end
            end
        endfunction

        function int pending();
            return expected_coeffs.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    rcmu_cfg_if                                       cfg_ch();
    rcmu_coeff_in_if  #(.MODULUS_BITS(MODULUS_BITS))  coeff_in_ch();
    rcmu_coeff_out_if #(.MODULUS_BITS(MODULUS_BITS))  coeff_out_ch();

    rescaled_coeff_tracker tracker = new;

    // quiet: no idling on either side for the closing stretch
    bit quiet          = 1'b0;
    // long_hold: receiver is in its long hold-off, sender keeps offering
    bit long_hold      = 1'b0;
    bit long_hold_done = 1'b0;
    int accepted_coeffs = 0;

    rescale_coefficient_modular_unit #(
        .MODULUS_BITS (MODULUS_BITS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_ch),
        .coeff_in  (coeff_in_ch),
        .coeff_out (coeff_out_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // generous cap, far above the slowest legal run
    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic bit [63:0] rand_word64();
        return {$urandom, $urandom};
    endfunction

    // uniform enough below a bound, full range when the bound is zero
    function automatic bit [63:0] rand_below(bit [63:0] bound);
        if (bound == 64'd0)
            return rand_word64();
        return rand_word64() % bound;
    endfunction

    // p^-1 mod q by extended euclid, meaningless when gcd is not one
    function automatic bit [63:0] inverse_mod(bit [63:0] p, bit [63:0] q);
        logic signed [127:0] r0;
        logic signed [127:0] r1;
        logic signed [127:0] rn;
        logic signed [127:0] t0;
        logic signed [127:0] t1;
        logic signed [127:0] tn;
        logic signed [127:0] quo;
        r0 = q;
        r1 = p % q;
        t0 = 0;
        t1 = 1;
        while (r1 != 0)
        begin
            quo = r0 / r1;
            tn  = t0 - quo * t1;
            t0  = t1;
            t1  = tn;
            rn  = r0 - quo * r1;
            r0  = r1;
            r1  = rn;
        end
        if (t0 < 0)
            t0 = t0 + q;
        return t0[63:0];
    endfunction

    // floor(y * 2^64 / q)
    function automatic bit [63:0] shoup_quotient(bit [63:0] y, bit [63:0] q);
        bit [127:0] scaled;
        scaled = {y, 64'd0};
        scaled = scaled / q;
        return scaled[63:0];
    endfunction

    function automatic coeff_word_t word_of(bit mode, bit [63:0] a, bit [63:0] b,
                                            bit [63:0] c, bit last);
        coeff_word_t w;
        w.mode = mode;
        w.a    = a[61:0];
        w.b    = b[61:0];
        w.c    = c[61:0];
        w.last = last;
        return w;
    endfunction

    // mostly reduced operands, a share of full-width ones to hit every bit
    function automatic coeff_word_t random_word();
        coeff_word_t w;
        w.mode = 1'($urandom_range(0, 1));
        w.last = ($urandom_range(0, 7) == 0);
        if ($urandom_range(0, 6) == 0)
        begin
            w.a = 62'(rand_word64());
            w.b = 62'(rand_word64());
            w.c = 62'(rand_word64());
        end
        else if (w.mode == MODE_REMAINDER)
        begin
            // b and c are don't-care here, keep them noisy
            w.a = 62'(rand_below(tracker.drop_modulus));
            w.b = 62'(rand_word64());
            w.c = 62'(rand_word64());
        end
        else
        begin
            w.a = 62'(rand_below(tracker.limb_modulus));
            w.b = 62'(rand_below(tracker.limb_modulus));
            w.c = 62'(rand_below(tracker.limb_modulus));
        end
        return w;
    endfunction

    // offer one word, with an occasional gap in front, and log it once taken
    task automatic send_word(coeff_word_t w);
        if (!quiet && !long_hold && $urandom_range(0, 3) == 0)
        begin
            coeff_in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        coeff_in_ch.valid   <= 1'b1;
        coeff_in_ch.mode    <= w.mode;
        coeff_in_ch.coeff_a <= w.a;
        coeff_in_ch.coeff_b <= w.b;
        coeff_in_ch.coeff_c <= w.c;
        coeff_in_ch.last_in <= w.last;
        do @(posedge clk); while (coeff_in_ch.ready !== 1'b1);
        tracker.note_word(w);
        accepted_coeffs++;
    endtask

    // one register write; valid stays up so writes can go back to back
    task automatic program_register(logic [CFG_INDEX_BITS-1:0] index, logic [63:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        tracker.write_register(index, data);
    endtask

    task automatic program_registers(bit [63:0] p, bit [63:0] half_p, bit [63:0] q,
                                     bit [63:0] one_quot, bit [63:0] inv_p,
                                     bit [63:0] inv_quot, bit spare);
        if (spare)
        begin
            // writes past the list must leave the registers alone
            program_register(REG_SPARE_LOW, '1);
            program_register(REG_SPARE_HIGH, '1);
        end
        program_register(REG_DROP_MODULUS, p);
        program_register(REG_HALF_DROP_MODULUS, half_p);
        program_register(REG_LIMB_MODULUS, q);
        program_register(REG_ONE_SHOUP_QUOT, one_quot);
        program_register(REG_INV_DROP_MODULUS, inv_p);
        program_register(REG_INV_SHOUP_QUOT, inv_quot);
        cfg_ch.valid <= 1'b0;
    endtask

    // a matching set of registers for the moduli p and q
    task automatic configure_moduli(bit [63:0] p, bit [63:0] q, bit spare);
        bit [63:0] inv_p;
        inv_p = inverse_mod(p, q);
        program_registers(p, p >> 1, q, shoup_quotient(64'd1, q), inv_p,
                          shoup_quotient(inv_p, q), spare);
    endtask

    // random words, then wait until every result is back so registers can change
    task automatic run_random(int count);
        repeat (count) send_word(random_word());
        coeff_in_ch.valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
    endtask

    // result side: every accepted output word is checked against the oldest due word
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && coeff_out_ch.valid === 1'b1 && coeff_out_ch.ready === 1'b1)
            tracker.check_result(coeff_out_ch.result_coeff, coeff_out_ch.last_out);
    end

    // receiver: random stall bursts, one long hold-off once the run is under way
    initial
    begin
        coeff_out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!quiet && !long_hold_done && accepted_coeffs >= 200)
            begin
                // pipeline fills behind the stalled output, input must back up
                long_hold = 1'b1;
                coeff_out_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                long_hold      = 1'b0;
                long_hold_done = 1'b1;
                coeff_out_ch.ready <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                coeff_out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
                coeff_out_ch.ready <= 1'b1;
            end
            else
            begin
                coeff_out_ch.ready <= 1'b1;
            end
        end
    end

    // stimulus: register settings in phases, corner words first, then random words
    initial
    begin
        bit [63:0] p;
        bit [63:0] q;
        bit [63:0] hf;

        rst_n               <= 1'b0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= REG_DROP_MODULUS;
        cfg_ch.data         <= 64'd0;
        coeff_in_ch.valid   <= 1'b0;
        coeff_in_ch.mode    <= MODE_REMAINDER;
        coeff_in_ch.coeff_a <= '0;
        coeff_in_ch.coeff_b <= '0;
        coeff_in_ch.coeff_c <= '0;
        coeff_in_ch.last_in <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // register defaults straight out of reset
        run_random(30);

        // matching moduli of random size, corner words first
        configure_moduli(64'd2 + rand_below(COEFF_MASK - 64'd1),
                         64'd2 + rand_below(COEFF_MASK - 64'd1), 1'b0);
        p  = tracker.drop_modulus;
        q  = tracker.limb_modulus;
        hf = tracker.half_drop_modulus;
        send_word(word_of(MODE_REMAINDER, 64'd0, 64'd0, 64'd0, 1'b0));
        // sum passes p, unused b and c all ones
        send_word(word_of(MODE_REMAINDER, p - 64'd1, COEFF_MASK, COEFF_MASK, 1'b1));
        // sum lands just under p, no correction
        send_word(word_of(MODE_REMAINDER, p - 64'd1 - hf, 64'd0, 64'd0, 1'b0));
        // sum lands exactly on p
        send_word(word_of(MODE_REMAINDER, p - hf, 64'd0, 64'd0, 1'b1));
        // dropped-limb coefficient not reduced
        send_word(word_of(MODE_REMAINDER, COEFF_MASK, 64'd0, 64'd0, 1'b0));
        send_word(word_of(MODE_FINISH, 64'd0, 64'd0, 64'd0, 1'b0));
        // a + b past q
        send_word(word_of(MODE_FINISH, q - 64'd1, q - 64'd1, 64'd0, 1'b1));
        // t below c, borrow path
        send_word(word_of(MODE_FINISH, 64'd1, 64'd0, q - 64'd1, 1'b0));
        // a + b wraps to zero, then borrow
        send_word(word_of(MODE_FINISH, q - 64'd1, 64'd1, 64'd1, 1'b0));
        // t equal to c gives zero
        send_word(word_of(MODE_FINISH, q - 64'd1, 64'd0, q - 64'd1, 1'b1));
        send_word(word_of(MODE_FINISH, q - 64'd1, q - 64'd1, q - 64'd1, 1'b0));
        // operands not reduced
        send_word(word_of(MODE_FINISH, COEFF_MASK, COEFF_MASK, COEFF_MASK, 1'b1));
        send_word(word_of(MODE_FINISH, 64'd0, 64'd0, COEFF_MASK, 1'b0));
        run_random(100);

        // tiny moduli, reductions trigger all the time
        configure_moduli(64'($urandom_range(2, 40)), 64'($urandom_range(2, 40)), 1'b0);
        run_random(80);

        // moduli at the top of the range, spare indexes written too
        configure_moduli(COEFF_MASK - 64'd2, COEFF_MASK, 1'b1);
        run_random(80);

        // every register written all ones, masked to its width
        program_registers('1, '1, '1, '1, '1, '1, 1'b1);
        run_random(60);

        // every register at its low end
        program_registers(64'd2, 64'd0, 64'd2, 64'd0, 64'd0, 64'd0, 1'b0);
        run_random(40);

        configure_moduli(64'd2 + rand_below(COEFF_MASK - 64'd1),
                         64'd2 + rand_below(COEFF_MASK - 64'd1), 1'b0);
        run_random(120);

        // registers that do not match each other
        program_registers(rand_word64(), rand_word64(), rand_word64(),
                          rand_word64(), rand_word64(), rand_word64(), 1'b0);
        run_random(60);

        // closing stretch at full rate on both sides
        configure_moduli(64'd2 + rand_below(COEFF_MASK - 64'd1),
                         64'd2 + rand_below(COEFF_MASK - 64'd1), 1'b0);
        quiet = 1'b1;
        run_random(80);

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
